// ----- rtl/stereo_dc_block_soft_clip_assert.svh -----
// ----------------------------------------------------------------------------
// stereo_dc_block_soft_clip_assert.svh
// assertion macros shared by the stereo master bus rtl
// ----------------------------------------------------------------------------
`ifndef STEREO_DC_BLOCK_SOFT_CLIP_ASSERT_SVH
`define STEREO_DC_BLOCK_SOFT_CLIP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SDCSC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define SDCSC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/sdcsc_pkg.sv -----
// ----------------------------------------------------------------------------
// sdcsc_pkg
// types, constants and the tanh table builder for the stereo master bus
// ----------------------------------------------------------------------------
package sdcsc_pkg;

    localparam int CHANNEL_COUNT    = 2;
    localparam int TANH_TABLE_DEPTH = 1024;
    localparam int IO_CHANNELS      = 2;

    // only the first min(CHANNEL_COUNT, IO_CHANNELS) channels are processed
    localparam int PROC_CH = (CHANNEL_COUNT < IO_CHANNELS) ? CHANNEL_COUNT : IO_CHANNELS;
    localparam int CH_W    = (PROC_CH > 1) ? $clog2(PROC_CH) : 1;

    localparam int X_W    = 24;
    localparam int Y_W    = 28;
    localparam int SUM_W  = 30;
    localparam int GAIN_W = 16;
    localparam int OUT_W  = 16;

    localparam int MUL_A_W = 44;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int ROM_AW = $clog2(TANH_TABLE_DEPTH + 1);
    localparam int IDX_W  = MUL_P_W - 34;
    localparam int FRAC_W = 16;

    localparam logic [MUL_B_W-1:0] DCB_R_Q16 = 16'd65208;
    localparam logic [MUL_B_W-1:0] DEPTH_MUL = MUL_B_W'(TANH_TABLE_DEPTH);
    localparam logic [OUT_W-1:0]   OUT_MAX   = 16'd32767;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MUTE_IDX = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_IDX = 8'd1;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    typedef struct packed {
        logic              mute;
        logic [GAIN_W-1:0] master_gain;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RMUL,
        S_FILT,
        S_GMUL,
        S_DMUL,
        S_ADDR,
        S_HI,
        S_IMUL,
        S_INTP,
        S_WAIT
    } state_t;

    typedef logic [OUT_W-1:0] tanh_rom_t [0:TANH_TABLE_DEPTH];

    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    // restoring long division, used only while building the table
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], n[b]};
            if (r >= d)
            begin
                r = r - d;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // exp(-f) in q30 for 0 <= f <= 1.0, taylor series
    function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
        logic signed [63:0] sum;
        logic [63:0]        term;
        sum  = $signed(ONE_Q30);
        term = ONE_Q30;
        for (int k = 1; k <= 24; k++)
        begin
            term = udiv64((term * f) >> 30, 64'(k));
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = '0;
        return $unsigned(sum);
    endfunction

    // tanh(8*i/depth) in q1.15, monotone, capped at 32767
    function automatic tanh_rom_t build_tanh_rom();
        tanh_rom_t   tab;
        logic [63:0] e1;
        logic [63:0] a;
        logic [63:0] n;
        logic [63:0] t;
        logic [63:0] den;
        logic [63:0] v;
        e1 = exp_neg_q30(ONE_Q30);
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++)
        begin
            a = (64'(i) << 34) / TANH_TABLE_DEPTH;
            n = a >> 30;
            t = exp_neg_q30(a & (ONE_Q30 - 64'd1));
            // whole part of 2x runs up to 16 at the top of the table
            for (int j = 0; j < 16; j++)
            begin
                if (64'(j) < n)
                    t = (t * e1) >> 30;
            end
            if (t > ONE_Q30)
                t = ONE_Q30;
            den = ONE_Q30 + t;
            v = udiv64(((ONE_Q30 - t) << 15) + (den >> 1), den);
            if (v > 64'd32767)
                v = 64'd32767;
            if (i > 0 && v < 64'(tab[i-1]))
                v = 64'(tab[i-1]);
            tab[i] = v[OUT_W-1:0];
        end
        return tab;
    endfunction

endpackage

// ----- rtl/sdcsc_if.sv -----
// ----------------------------------------------------------------------------
// sdcsc_if
// valid/ready channels of the stereo master bus: frames, results, config
// ----------------------------------------------------------------------------
interface sdcsc_in_if
    import sdcsc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] left_in;
    logic signed [X_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sdcsc_out_if
    import sdcsc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] left_out;
    logic signed [OUT_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

interface sdcsc_cfg_if
    import sdcsc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/sdcsc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// sdcsc_cfg_regs
// mute and master gain registers behind the config write channel
// ----------------------------------------------------------------------------
module sdcsc_cfg_regs
    import sdcsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sdcsc_cfg_if.sink   cfg,
    output cfg_t        regs
);

    cfg_t regs_reg;
    cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    // unknown indexes are dropped
    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_MUTE_IDX: regs_next.mute        = cfg.data[0];
                CFG_GAIN_IDX: regs_next.master_gain = cfg.data[GAIN_W-1:0];
                default:      regs_next             = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.mute        <= 1'b0;
            regs_reg.master_gain <= GAIN_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ----- rtl/sdcsc_mul.sv -----
// ----------------------------------------------------------------------------
// sdcsc_mul
// shared unsigned 44x16 multiplier with a registered product
// ----------------------------------------------------------------------------
module sdcsc_mul
    import sdcsc_pkg::*;
(
    input  logic               clk,
    input  logic [MUL_A_W-1:0] a,
    input  logic [MUL_B_W-1:0] b,
    output logic [MUL_P_W-1:0] prod
);

    logic [MUL_P_W-1:0] prod_reg;
    logic [MUL_P_W-1:0] prod_next;

    assign prod_next = {{MUL_B_W{1'b0}}, a} * {{MUL_A_W{1'b0}}, b};
    assign prod      = prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

endmodule

// ----- rtl/sdcsc_tanh_rom.sv -----
// ----------------------------------------------------------------------------
// sdcsc_tanh_rom
// tanh table over [0, 8] in q1.15, one registered read per cycle
// ----------------------------------------------------------------------------
module sdcsc_tanh_rom
    import sdcsc_pkg::*;
(
    input  logic              clk,
    input  logic [ROM_AW-1:0] addr,
    output logic [OUT_W-1:0]  q
);

    localparam tanh_rom_t TANH_ROM = build_tanh_rom();

    logic [OUT_W-1:0] q_reg;

    assign q = q_reg;

    always_ff @(posedge clk)
    begin
        q_reg <= TANH_ROM[addr];
    end

endmodule

// ----- rtl/stereo_dc_block_soft_clip.sv -----
// ----------------------------------------------------------------------------
// stereo_dc_block_soft_clip
// stereo master bus: dc blocker, master gain and tanh soft clip
// ----------------------------------------------------------------------------
// One stereo frame is taken at a time on the frame channel. A processed frame
// passes accept, then per channel the pole product, filter, gain, scaling,
// two rom reads and interpolation states, then hand-off; a frame taken while
// muted goes from accept to hand-off and yields zeros without touching the
// filter state. The order is set by the single shared 44x16 multiplier
// (pole product, gain, table scaling and interpolation) and by the one tanh
// rom read port, which fetches the two neighbor entries in turn. The next
// frame is taken while a finished result still waits in the output register.
// Config writes are taken in any cycle; no clearing pass runs after reset.
`include "stereo_dc_block_soft_clip_assert.svh"

module stereo_dc_block_soft_clip
    import sdcsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sdcsc_in_if.sink    frame,
    sdcsc_out_if.source processed,
    sdcsc_cfg_if.sink   cfg
);

    localparam logic signed [SUM_W-1:0] SUM_Y_MAX = SUM_W'(2 ** (Y_W - 1) - 1);
    localparam logic signed [SUM_W-1:0] SUM_Y_MIN = -SUM_Y_MAX - SUM_W'(1);

    cfg_t regs;

    state_t state_reg;
    state_t state_next;

    logic [CH_W-1:0] ch_reg;

    logic signed [X_W-1:0] left_in_reg;
    logic signed [X_W-1:0] right_in_reg;

    logic signed [X_W-1:0] prev_input_reg    [0:PROC_CH-1];
    logic signed [Y_W-1:0] prev_filtered_reg [0:PROC_CH-1];

    logic signed [Y_W-1:0] y_reg;
    logic                  neg_reg;
    logic [ROM_AW-1:0]     idx_reg;
    logic [FRAC_W-1:0]     frac_reg;
    logic                  sat_reg;
    logic [OUT_W-1:0]      lo_reg;

    logic signed [OUT_W-1:0] res_reg [0:IO_CHANNELS-1];

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] left_out_reg;
    logic signed [OUT_W-1:0] right_out_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] prod;
    logic [ROM_AW-1:0]  rom_addr;
    logic [OUT_W-1:0]   rom_q;
    logic               frame_ready;

    logic                  frame_take;
    logic                  slot_free;
    logic                  last_ch;
    logic signed [X_W-1:0] x_cur;
    logic signed [X_W-1:0] xp_cur;
    logic signed [Y_W-1:0] yp_cur;
    logic [Y_W-1:0]        yp_mag;
    logic [Y_W-1:0]        y_mag;
    logic [Y_W-1:0]        ry_mag;
    logic signed [SUM_W-1:0] ry;
    logic signed [SUM_W-1:0] sum;
    logic signed [Y_W-1:0]   y_new;
    logic [IDX_W-1:0]        idx_full;
    logic [32:0]             step;
    logic [OUT_W:0]          r_sum;
    logic [OUT_W-1:0]        r_cap;
    logic signed [OUT_W-1:0] r_signed;

    sdcsc_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    sdcsc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    sdcsc_tanh_rom u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    assign frame.ready = frame_ready;
    assign frame_take  = frame.valid && frame_ready;
    assign slot_free   = !out_valid_reg || processed.ready;
    assign last_ch     = (ch_reg == CH_W'(PROC_CH - 1));

    assign processed.valid     = out_valid_reg;
    assign processed.left_out  = left_out_reg;
    assign processed.right_out = right_out_reg;

    // filter arithmetic
    assign x_cur  = (ch_reg == '0) ? left_in_reg : right_in_reg;
    assign xp_cur = prev_input_reg[ch_reg];
    assign yp_cur = prev_filtered_reg[ch_reg];
    assign yp_mag = yp_cur[Y_W-1] ? $unsigned(-yp_cur) : $unsigned(yp_cur);
    assign y_mag  = y_reg[Y_W-1] ? $unsigned(-y_reg) : $unsigned(y_reg);

    // pole product truncates toward zero on the magnitude
    assign ry_mag = prod[Y_W+15:16];
    assign ry     = yp_cur[Y_W-1] ? -$signed({2'b00, ry_mag}) : $signed({2'b00, ry_mag});
    assign sum    = SUM_W'(x_cur) - SUM_W'(xp_cur) + ry;
    assign y_new  = (sum > SUM_Y_MAX) ? SUM_Y_MAX[Y_W-1:0] :
                    (sum < SUM_Y_MIN) ? SUM_Y_MIN[Y_W-1:0] : sum[Y_W-1:0];

    // table lookup and interpolation
    assign idx_full = prod[MUL_P_W-1:34];
    assign step     = {1'b0, prod[31:0]} + 33'd32768;
    assign r_sum    = {1'b0, lo_reg} + step[OUT_W+16:16];
    assign r_cap    = (sat_reg || r_sum > {1'b0, OUT_MAX}) ? OUT_MAX : r_sum[OUT_W-1:0];
    assign r_signed = neg_reg ? -$signed(r_cap) : $signed(r_cap);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (frame.valid)
                    state_next = regs.mute ? S_WAIT : S_RMUL;
            end
            S_RMUL: state_next = S_FILT;
            S_FILT: state_next = S_GMUL;
            S_GMUL: state_next = S_DMUL;
            S_DMUL: state_next = S_ADDR;
            S_ADDR: state_next = S_HI;
            S_HI:   state_next = S_IMUL;
            S_IMUL: state_next = S_INTP;
            S_INTP: state_next = last_ch ? S_WAIT : S_RMUL;
            S_WAIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs: operand select, rom address and frame ready
    always_comb
    begin
        mul_a       = '0;
        mul_b       = '0;
        rom_addr    = idx_reg;
        frame_ready = 1'b0;
        case (state_reg)
            S_IDLE: frame_ready = 1'b1;
            S_RMUL:
            begin
                mul_a = MUL_A_W'(yp_mag);
                mul_b = DCB_R_Q16;
            end
            S_GMUL:
            begin
                mul_a = MUL_A_W'(y_mag);
                mul_b = regs.master_gain;
            end
            S_DMUL:
            begin
                mul_a = prod[MUL_A_W-1:0];
                mul_b = DEPTH_MUL;
            end
            S_ADDR: rom_addr = idx_full[ROM_AW-1:0];
            S_HI:   rom_addr = idx_reg + ROM_AW'(1);
            S_IMUL:
            begin
                mul_a = MUL_A_W'(rom_q - lo_reg);
                mul_b = frac_reg;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < PROC_CH; c++)
            begin
                prev_input_reg[c]    <= '0;
                prev_filtered_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (frame_take)
                ch_reg <= '0;
            else if (state_reg == S_INTP && !last_ch)
                ch_reg <= ch_reg + CH_W'(1);
            if (state_reg == S_FILT)
            begin
                prev_input_reg[ch_reg]    <= x_cur;
                prev_filtered_reg[ch_reg] <= y_new;
            end
            if (state_reg == S_WAIT && slot_free)
                out_valid_reg <= 1'b1;
            else if (processed.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            left_in_reg  <= frame.left_in;
            right_in_reg <= frame.right_in;
            for (int c = 0; c < IO_CHANNELS; c++)
                res_reg[c] <= '0;
        end
        case (state_reg)
            S_FILT: y_reg <= y_new;
            S_GMUL: neg_reg <= y_reg[Y_W-1];
            S_ADDR:
            begin
                idx_reg  <= idx_full[ROM_AW-1:0];
                frac_reg <= prod[33:18];
                sat_reg  <= (idx_full >= IDX_W'(TANH_TABLE_DEPTH));
            end
            S_HI:   lo_reg <= rom_q;
            S_INTP: res_reg[ch_reg] <= r_signed;
            default:
            begin
                y_reg <= y_reg;
            end
        endcase
        if (state_reg == S_WAIT && slot_free)
        begin
            left_out_reg  <= res_reg[0];
            right_out_reg <= res_reg[1];
        end
    end

    // a muted frame skips the filter and goes straight to hand-off
    `SDCSC_ASSERT_NEXT(a_mute_bypass, frame_take && regs.mute, state_reg == S_WAIT, "muted frame entered the filter")
    // results never reach the negative full-scale code
    `SDCSC_ASSERT_NOW(a_out_range, out_valid_reg, left_out_reg != 16'sh8000 && right_out_reg != 16'sh8000, "result outside +-32767")
    // a finished frame lands in the output register once the slot frees
    `SDCSC_ASSERT_NEXT(a_handoff, state_reg == S_WAIT && slot_free, out_valid_reg && state_reg == S_IDLE, "finished frame not handed off")

endmodule

// ----- tb/sdcsc_bus_checker.sv -----
// ----------------------------------------------------------------------------
// sdcsc_bus_checker
// watches the frame, result and config channels of the stereo master bus,
// predicts every processed frame and compares it field by field
// ----------------------------------------------------------------------------
module sdcsc_bus_checker
    import sdcsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sdcsc_in_if         frame,
    sdcsc_out_if        processed,
    sdcsc_cfg_if        cfg,
    output int unsigned mismatches,
    output int unsigned frames_outstanding
);

    localparam longint UNITY_Q30 = 64'sd1 << 30;
    localparam longint POLE_Q16  = 65208;
    localparam longint FILT_MAX  = (64'sd1 << (Y_W - 1)) - 1;
    localparam longint FILT_MIN  = -(64'sd1 << (Y_W - 1));
    localparam longint CLIP_MAX  = 32767;

    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] right;
    } stereo_out_t;

    stereo_out_t expected_frames [$];

    logic [OUT_W-1:0]        tanh_lut [0:TANH_TABLE_DEPTH];
    logic signed [X_W-1:0]   last_in   [CHANNEL_COUNT];
    logic signed [Y_W-1:0]   last_filt [CHANNEL_COUNT];
    logic                    muted;
    logic [GAIN_W-1:0]       gain_q412;
    int unsigned             results_seen;

    // exp(-f) in q30 for 0 <= f <= 1.0, taylor series to 24 terms
    function automatic longint exp_neg_fix(input longint f);
        longint acc;
        longint term;
        acc  = UNITY_Q30;
        term = UNITY_Q30;
        for (int k = 1; k <= 24; k++)
        begin
            term = ((term * f) >>> 30) / longint'(k);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        if (acc < 0)
            acc = 0;
        return acc;
    endfunction

    initial
    begin : build_lut
        longint e1;
        longint a;
        longint n;
        longint t;
        longint den;
        longint v;
        e1 = exp_neg_fix(UNITY_Q30);
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++)
        begin
            // 2x in q30, split into whole part and fraction
            a = (longint'(i) << 34) / longint'(TANH_TABLE_DEPTH);
            n = a >>> 30;
            t = exp_neg_fix(a & (UNITY_Q30 - 1));
            for (longint j = 0; j < n; j++)
                t = (t * e1) >>> 30;
            if (t > UNITY_Q30)
                t = UNITY_Q30;
            den = UNITY_Q30 + t;
            v = (((UNITY_Q30 - t) << 15) + (den >>> 1)) / den;
            if (v > CLIP_MAX)
                v = CLIP_MAX;
            if (i > 0 && v < longint'(tanh_lut[i-1]))
                v = longint'(tanh_lut[i-1]);
            tanh_lut[i] = v[OUT_W-1:0];
        end
    end

    function automatic longint dc_block_step(input int ch, input longint x);
        longint yp;
        longint mag;
        longint ry;
        longint y;
        yp  = longint'(last_filt[ch]);
        mag = (yp < 0) ? -yp : yp;
        // pole product truncates toward zero so the filter settles at zero
        ry  = (mag * POLE_Q16) >>> 16;
        if (yp < 0)
            ry = -ry;
        y = x - longint'(last_in[ch]) + ry;
        if (y > FILT_MAX)
            y = FILT_MAX;
        if (y < FILT_MIN)
            y = FILT_MIN;
        last_in[ch]   = x[X_W-1:0];
        last_filt[ch] = y[Y_W-1:0];
        return y;
    endfunction

    function automatic longint soft_clip_step(input longint y);
        longint v;
        longint m;
        longint s;
        longint idx;
        longint frac;
        longint lo;
        longint hi;
        longint r;
        v    = y * longint'(gain_q412);
        m    = (v < 0) ? -v : v;
        s    = m * longint'(TANH_TABLE_DEPTH);
        idx  = s >>> 34;
        frac = (s >>> 18) & 64'hFFFF;
        if (idx >= TANH_TABLE_DEPTH)
            r = CLIP_MAX;
        else
        begin
            lo = longint'(tanh_lut[idx]);
            hi = longint'(tanh_lut[idx + 1]);
            r  = lo + (((hi - lo) * frac + 32768) >>> 16);
            if (r > CLIP_MAX)
                r = CLIP_MAX;
        end
        return (v < 0) ? -r : r;
    endfunction

    function automatic stereo_out_t predict_frame(input logic signed [X_W-1:0] left,
                                                  input logic signed [X_W-1:0] right);
        stereo_out_t          res;
        longint               r;
        logic signed [X_W-1:0] x [IO_CHANNELS];
        logic [OUT_W-1:0]     o [IO_CHANNELS];
        x[0] = left;
        x[1] = right;
        for (int ch = 0; ch < IO_CHANNELS; ch++)
        begin
            r = 0;
            if (!muted && ch < CHANNEL_COUNT)
                r = soft_clip_step(dc_block_step(ch, longint'(x[ch])));
            o[ch] = r[OUT_W-1:0];
        end
        res.left  = o[0];
        res.right = o[1];
        return res;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d",
                 results_seen, field, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stereo_out_t want;
        if (!rst_n)
        begin
            for (int ch = 0; ch < CHANNEL_COUNT; ch++)
            begin
                last_in[ch]   = '0;
                last_filt[ch] = '0;
            end
            muted              = 1'b0;
            gain_q412          = GAIN_RESET;
            results_seen       = 0;
            mismatches         = 0;
            frames_outstanding = 0;
            expected_frames.delete();
        end
        else
        begin
            if (processed.valid && processed.ready)
            begin
                if (expected_frames.size() == 0)
                    report_mismatch("unexpected item, left_out", processed.left_out, 0);
                else
                begin
                    want = expected_frames.pop_front();
                    if (processed.left_out !== want.left)
                        report_mismatch("left_out", processed.left_out, want.left);
                    if (processed.right_out !== want.right)
                        report_mismatch("right_out", processed.right_out, want.right);
                end
                results_seen++;
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_MUTE_IDX)
                    muted = cfg.data[0];
                else if (cfg.index == CFG_GAIN_IDX)
                    gain_q412 = cfg.data[GAIN_W-1:0];
            end
            if (frame.valid && frame.ready)
                expected_frames.push_back(predict_frame(frame.left_in, frame.right_in));
            frames_outstanding = expected_frames.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// drives frames and config writes into the stereo master bus and gives the
// verdict; a directed set of extremes, mute and gain corners comes first,
// then random segments under many gain settings and three stall patterns
// ----------------------------------------------------------------------------
module tb_top;
    import sdcsc_pkg::*;

    localparam logic signed [X_W-1:0]   SAMPLE_MAX    = 24'sh7FFFFF;
    localparam logic signed [X_W-1:0]   SAMPLE_MIN    = 24'sh800000;
    localparam logic [CFG_IDX_W-1:0]    CFG_SPARE_IDX = 8'd9;
    localparam int unsigned             QUIET_LIMIT   = 4000;
    localparam int unsigned             SEGMENTS      = 12;

    logic        clk = 1'b0;
    logic        rst_n;
    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    int unsigned quiet_cycles;
    int unsigned mismatches;
    int unsigned frames_outstanding;

    sdcsc_in_if  frame_ch ();
    sdcsc_out_if result_ch ();
    sdcsc_cfg_if cfg_ch ();

    stereo_dc_block_soft_clip dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .frame     (frame_ch),
        .processed (result_ch),
        .cfg       (cfg_ch)
    );

    sdcsc_bus_checker checker_i (
        .clk                (clk),
        .rst_n              (rst_n),
        .frame              (frame_ch),
        .processed          (result_ch),
        .cfg                (cfg_ch),
        .mismatches         (mismatches),
        .frames_outstanding (frames_outstanding)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles <= 0;
        else
        begin
            if ((frame_ch.valid && frame_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("*** FAILED ***");
                    $finish;
                end
            end
        end
    end

    task automatic push_frame(input logic signed [X_W-1:0] left,
                              input logic signed [X_W-1:0] right);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid    <= 1'b1;
        frame_ch.left_in  <= left;
        frame_ch.right_in <= right;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
    endtask

    // block is idle once every frame taken has come back
    task automatic wait_drained();
        frame_ch.valid <= 1'b0;
        @(negedge clk);
        while (frames_outstanding != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // mix of full-range noise, corners, small levels and slow wander
    function automatic logic signed [X_W-1:0] next_sample(input logic signed [X_W-1:0] prev);
        logic [X_W-1:0] raw;
        longint         walk;
        int unsigned    width;
        raw   = X_W'($urandom());
        width = $urandom_range(0, 22);
        case ($urandom_range(0, 9))
            0, 1, 2, 3:
                return raw;
            4:
            begin
                case ($urandom_range(0, 4))
                    0:       return SAMPLE_MAX;
                    1:       return SAMPLE_MIN;
                    2:       return '0;
                    3:       return -24'sd1;
                    default: return 24'sd1;
                endcase
            end
            5, 6:
            begin
                walk = longint'($urandom_range(0, (1 << width) - 1));
                if (raw[0])
                    walk = -walk;
                return walk[X_W-1:0];
            end
            default:
            begin
                walk = longint'(prev) + (longint'($signed(raw[15:0])) >>> $urandom_range(0, 8));
                if (walk > longint'(SAMPLE_MAX))
                    walk = longint'(SAMPLE_MAX);
                if (walk < longint'(SAMPLE_MIN))
                    walk = longint'(SAMPLE_MIN);
                return walk[X_W-1:0];
            end
        endcase
    endfunction

    initial
    begin
        logic signed [X_W-1:0]  left_s;
        logic signed [X_W-1:0]  right_s;
        logic [CFG_DATA_W-1:0]  word;
        int unsigned            seg_len;
        bit                     muted_seg;

        rst_n              <= 1'b0;
        frame_ch.valid     <= 1'b0;
        frame_ch.left_in   <= '0;
        frame_ch.right_in  <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= '0;
        cfg_ch.data        <= '0;
        sender_idle_pct    = 27;
        receiver_idle_pct  = 52;
        left_s             = '0;
        right_s            = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners under the reset settings
        push_frame('0, '0);
        push_frame(SAMPLE_MAX, SAMPLE_MIN);
        push_frame(SAMPLE_MIN, SAMPLE_MAX);
        push_frame(SAMPLE_MAX, SAMPLE_MAX);
        push_frame(SAMPLE_MAX, SAMPLE_MAX);
        push_frame(SAMPLE_MIN, SAMPLE_MIN);
        push_frame('0, '0);
        // a one-lsb step must decay to exactly zero
        push_frame(24'sd1, -24'sd1);
        push_frame('0, '0);
        push_frame('0, '0);

        wait_drained();
        write_reg(CFG_GAIN_IDX, 16'hFFFF);
        push_frame(24'sd4096, -24'sd4096);
        push_frame(SAMPLE_MAX, SAMPLE_MIN);
        push_frame('0, '0);

        wait_drained();
        write_reg(CFG_GAIN_IDX, 16'h0000);
        push_frame(SAMPLE_MIN, SAMPLE_MAX);
        push_frame(24'sd12345, -24'sd777);

        // muted frames give zeros and leave the filter alone
        wait_drained();
        write_reg(CFG_GAIN_IDX, GAIN_RESET);
        write_reg(CFG_MUTE_IDX, 16'hFFFF);
        push_frame(SAMPLE_MAX, SAMPLE_MIN);
        push_frame(24'sd123, -24'sd456);
        wait_drained();
        write_reg(CFG_MUTE_IDX, 16'hFFFE);
        push_frame(24'sd100000, -24'sd100000);

        // write to an unused index must change nothing
        wait_drained();
        write_reg(CFG_SPARE_IDX, 16'hFFFF);
        push_frame(SAMPLE_MAX, SAMPLE_MIN);
        push_frame('0, '0);

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            if (seg < SEGMENTS / 3)
            begin
                sender_idle_pct   = 27;
                receiver_idle_pct = 52;
            end
            else if (seg < 2 * SEGMENTS / 3)
            begin
                sender_idle_pct   = 52;
                receiver_idle_pct = 27;
            end
            else
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            case (seg)
                0:       word = GAIN_RESET;
                1:       word = 16'h0000;
                2:       word = 16'hFFFF;
                3:       word = 16'h0001;
                4:       word = 16'h0800;
                5:       word = 16'h8000;
                6:       word = 16'h2000;
                7:       word = 16'hFFFF;
                default: word = CFG_DATA_W'((seg % 2 == 1) ? $urandom_range(0, 8191)
                                                           : $urandom_range(0, 65535));
            endcase
            muted_seg = (seg == 3) || (seg == 9);
            wait_drained();
            write_reg(CFG_GAIN_IDX, word);
            if (muted_seg)
            begin
                word = CFG_DATA_W'($urandom_range(0, 65535));
                write_reg(CFG_MUTE_IDX, word | 16'h0001);
            end
            seg_len = muted_seg ? 30 : 120;
            for (int n = 0; n < seg_len; n++)
            begin
                left_s  = next_sample(left_s);
                right_s = next_sample(right_s);
                push_frame(left_s, right_s);
            end
            if (muted_seg)
            begin
                wait_drained();
                word = CFG_DATA_W'($urandom_range(0, 65535));
                write_reg(CFG_MUTE_IDX, word & 16'hFFFE);
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
